[hw/rtl/orsl_pkg.sv]
// Shared types and constants for the overwrite ring sample log.
// Request, result and record layouts plus the controller state encoding.
// No dependencies.
package orsl_pkg;

  localparam int AGE_W   = 10;
  localparam int COUNT_W = 11;
  localparam int TOTAL_W = 32;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_DRAIN  = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [AGE_W-1:0]   age_index;
    logic [31:0]        in_timestamp;
    logic signed [15:0] in_pit_temp;
    logic signed [15:0] in_probe_one_temp;
    logic signed [15:0] in_probe_two_temp;
    logic [6:0]         in_fan_percent;
    logic [6:0]         in_damper_percent;
    logic [7:0]         in_flag_bits;
  } req_t;

  typedef struct packed {
    logic                record_valid;
    logic [31:0]         out_timestamp;
    logic signed [15:0]  out_pit_temp;
    logic signed [15:0]  out_probe_one_temp;
    logic signed [15:0]  out_probe_two_temp;
    logic [6:0]          out_fan_percent;
    logic [6:0]          out_damper_percent;
    logic [7:0]          out_flag_bits;
    logic [COUNT_W-1:0]  stored_count;
    logic [COUNT_W-1:0]  pending_count;
    logic [TOTAL_W-1:0]  total_appended;
  } resp_t;

  // One stored record as it sits in the ring memory.
  typedef struct packed {
    logic [31:0]        timestamp;
    logic signed [15:0] pit_temp;
    logic signed [15:0] probe_one_temp;
    logic signed [15:0] probe_two_temp;
    logic [6:0]         fan_percent;
    logic [6:0]         damper_percent;
    logic [7:0]         flag_bits;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

endpackage

[hw/rtl/orsl_ctrl.sv]
// Request sequencer for the overwrite ring sample log.
// Steps each request through capture, execute and respond; uses orsl_pkg.
module orsl_ctrl
  import orsl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    done        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = ST_RESP;
      end
      ST_RESP: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

[hw/rtl/orsl_dp.sv]
// Datapath of the overwrite ring sample log: record memory, ring pointers,
// counters and result assembly. Uses orsl_pkg; driven by orsl_ctrl commands.
module orsl_dp
  import orsl_pkg::*;
#(
  parameter int LOG_DEPTH = 1024
) (
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  input  req_t  req,
  output resp_t resp
);

  localparam int PTR_W = $clog2(LOG_DEPTH);
  localparam int CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int SUM_W = ((PTR_W > AGE_W) ? PTR_W : AGE_W) + 1;
  localparam int CMP_W = (CNT_W > AGE_W) ? CNT_W : AGE_W;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LOG_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(LOG_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(LOG_DEPTH - 1);

  rec_t mem [LOG_DEPTH];
  rec_t rd_q;
  rec_t rec_in;

  req_t               req_q;
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   oldest_ptr;
  logic [PTR_W-1:0]   drain_ptr;
  logic [CNT_W-1:0]   held;
  logic [CNT_W-1:0]   undrained;
  logic [TOTAL_W-1:0] total;
  logic               rec_hit;

  logic [PTR_W-1:0] wr_ptr_inc;
  logic [PTR_W-1:0] oldest_inc;
  logic [PTR_W-1:0] drain_inc;
  logic [SUM_W-1:0] age_sum;
  logic [PTR_W-1:0] age_slot;
  logic [PTR_W-1:0] rd_addr;
  logic             age_hit;
  logic             held_full;
  logic             pend_full;

  // oldest_ptr tracks the oldest held slot and drain_ptr the oldest pending
  // slot, so neither request needs a subtraction from the write pointer.
  always_comb begin
    wr_ptr_inc = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
    oldest_inc = (oldest_ptr == LAST_PTR) ? '0 : oldest_ptr + PTR_W'(1);
    drain_inc  = (drain_ptr == LAST_PTR) ? '0 : drain_ptr + PTR_W'(1);
    held_full  = (held == DEPTH_CNT);
    pend_full  = (undrained == DEPTH_CNT);
    age_hit    = (CMP_W'(req_q.age_index) < CMP_W'(held));
    // A hit has age below the held count, so the sum stays under twice the depth.
    age_sum    = SUM_W'(oldest_ptr) + SUM_W'(req_q.age_index);
    age_slot   = (age_sum >= DEPTH_SUM) ? PTR_W'(age_sum - DEPTH_SUM) : PTR_W'(age_sum);
    rd_addr    = (req_q.req_type == REQ_DRAIN) ? drain_ptr : age_slot;

    rec_in.timestamp      = req_q.in_timestamp;
    rec_in.pit_temp       = req_q.in_pit_temp;
    rec_in.probe_one_temp = req_q.in_probe_one_temp;
    rec_in.probe_two_temp = req_q.in_probe_two_temp;
    rec_in.fan_percent    = req_q.in_fan_percent;
    rec_in.damper_percent = req_q.in_damper_percent;
    rec_in.flag_bits      = req_q.in_flag_bits;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && (req_q.req_type == REQ_APPEND)) begin
      mem[wr_ptr] <= rec_in;
    end
    if (cmd.execute) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      oldest_ptr <= '0;
      drain_ptr  <= '0;
      held       <= '0;
      undrained  <= '0;
      total      <= '0;
      rec_hit    <= 1'b0;
    end else if (cmd.execute) begin
      unique case (req_q.req_type)
        REQ_APPEND: begin
          rec_hit <= 1'b0;
          wr_ptr  <= wr_ptr_inc;
          total   <= total + TOTAL_W'(1);
          if (held_full) begin
            oldest_ptr <= oldest_inc;
          end else begin
            held <= held + CNT_W'(1);
          end
          if (pend_full) begin
            drain_ptr <= drain_inc;
          end else begin
            undrained <= undrained + CNT_W'(1);
          end
        end
        REQ_READ: begin
          rec_hit <= age_hit;
        end
        REQ_DRAIN: begin
          rec_hit <= (undrained != '0);
          if (undrained != '0) begin
            undrained <= undrained - CNT_W'(1);
            drain_ptr <= drain_inc;
          end
        end
        REQ_CLEAR: begin
          rec_hit    <= 1'b0;
          wr_ptr     <= '0;
          oldest_ptr <= '0;
          drain_ptr  <= '0;
          held       <= '0;
          undrained  <= '0;
          total      <= '0;
        end
      endcase
    end
  end

  always_comb begin
    resp.record_valid       = rec_hit;
    resp.out_timestamp      = rec_hit ? rd_q.timestamp : '0;
    resp.out_pit_temp       = rec_hit ? rd_q.pit_temp : '0;
    resp.out_probe_one_temp = rec_hit ? rd_q.probe_one_temp : '0;
    resp.out_probe_two_temp = rec_hit ? rd_q.probe_two_temp : '0;
    resp.out_fan_percent    = rec_hit ? rd_q.fan_percent : '0;
    resp.out_damper_percent = rec_hit ? rd_q.damper_percent : '0;
    resp.out_flag_bits      = rec_hit ? rd_q.flag_bits : '0;
    resp.stored_count       = COUNT_W'(held);
    resp.pending_count      = COUNT_W'(undrained);
    resp.total_appended     = total;
  end

endmodule

[hw/rtl/overwrite_ring_sample_log.sv]
// Top level of the overwrite ring sample log.
// Instantiates orsl_ctrl and orsl_dp; types come from orsl_pkg.

// Ring of LOG_DEPTH logged sensor records that overwrites the oldest record
// when full. A request (append, read by age, drain, clear) is taken on a
// clock edge where start is high and busy is low, and every request gives
// exactly one result: done is high for one cycle with the result on resp,
// in the respond state that follows the execute state. The receiver cannot
// hold a result off, so it must take resp in the cycle done is high. Busy
// stays high through the done cycle, so the next request is accepted only
// once the sequencer is back in idle: a new request is never taken before
// the last one has given its result. Each request has the record memory
// access with its registered read data, then the result is presented, and
// then the sequencer is back in idle, where the next request is taken.
// Reads and drains that find no record return record_valid low with all
// record fields zero; the counts and the append total are always reported
// as they stand after the request. The record memory needs no clearing
// pass: only held records are ever returned, so the block is ready right
// after reset.
module overwrite_ring_sample_log
  import orsl_pkg::*;
#(
  parameter int LOG_DEPTH = 1024
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  req_t  req,
  output logic  done,
  output resp_t resp
);

  cmd_t cmd;

  // Sequencer: walks each request through capture, execute and respond.
  orsl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Datapath: record memory, ring pointers, counters and the result.
  orsl_dp #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .resp (resp)
  );

endmodule

[hw/rtl/orsl_checker.sv]
// Port-level checks for the overwrite ring sample log.
// Uses orsl_pkg; bound to overwrite_ring_sample_log below.
module orsl_checker
  import orsl_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  start,
  input logic  busy,
  input logic  done,
  input resp_t resp
);

  // Every accepted request is followed by its result strobe on done.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result did not follow request");

  // A result only appears while a request is in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe without request in flight");

  // One result per request: the strobe is never repeated back to back.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

  // A result without a record carries zero timestamp, pit temperature and flag fields.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !resp.record_valid) |->
      (resp.out_timestamp == '0 && resp.out_pit_temp == '0 &&
       resp.out_flag_bits == '0))
    else $error("record fields not zero without record");

endmodule

bind overwrite_ring_sample_log orsl_checker u_orsl_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .resp  (resp)
);

[dv/overwrite_ring_sample_log_tb.sv]
// Self-checking testbench for the overwrite ring sample log.
// Depends on orsl_pkg for the request and result layouts and on the
// overwrite_ring_sample_log top level; it needs nothing else.
module overwrite_ring_sample_log_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import orsl_pkg::*;

  // The block runs at its shipped depth, so the random part has to fill
  // the whole ring to reach the overwrite and saturation behavior.
  localparam int DEPTH       = 1024;
  localparam int RESET_LEN   = 12;
  localparam int TAIL_CYCLES = 8;
  // The slowest correct run is about 1700 requests, each with its block time
  // plus a random gap, which keeps it well inside CYCLE_LIMIT.
  localparam int CYCLE_LIMIT = 400000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  logic  done;
  req_t  req = '0;
  resp_t resp;

  overwrite_ring_sample_log #(
    .LOG_DEPTH(DEPTH)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .resp (resp)
  );

  always #5 clk = ~clk;

  // Requests waiting for the driver, and results predicted for requests
  // the block has already taken, oldest first.
  req_t  queued_reqs[$];
  resp_t predicted_log[$];

  int mismatches = 0;
  int result_no = 0;
  int cycles = 0;

  // ---------------------------------------------------------------------
  // Predictor: a private copy of the ring and its counters. It is stepped
  // once for every request the block accepts.
  // ---------------------------------------------------------------------
  rec_t        ring[DEPTH];
  int unsigned wr_ptr = 0;
  int unsigned held = 0;
  int unsigned undrained = 0;
  logic [31:0] total = '0;

  task automatic log_ring_step(input req_t r, output resp_t o);
    int unsigned age;
    logic        found;
    rec_t        rec;
    age   = 0;
    found = 1'b0;
    rec   = '0;
    o     = '0;
    case (r.req_type)
      REQ_APPEND: begin
        rec.timestamp      = r.in_timestamp;
        rec.pit_temp       = r.in_pit_temp;
        rec.probe_one_temp = r.in_probe_one_temp;
        rec.probe_two_temp = r.in_probe_two_temp;
        rec.fan_percent    = r.in_fan_percent;
        rec.damper_percent = r.in_damper_percent;
        rec.flag_bits      = r.in_flag_bits;
        ring[wr_ptr] = rec;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        // When the ring is full the oldest record is overwritten, and an
        // overwritten record that was still pending is simply lost.
        if (held < DEPTH) held++;
        if (undrained < DEPTH) undrained++;
        total = total + 32'd1;
      end
      REQ_READ: begin
        if (r.age_index < held) begin
          age   = r.age_index;
          found = 1'b1;
        end
      end
      REQ_DRAIN: begin
        // The oldest pending record sits right after the drained ones.
        if (undrained > 0) begin
          age   = held - undrained;
          found = 1'b1;
          undrained--;
        end
      end
      default: begin
        wr_ptr    = 0;
        held      = 0;
        undrained = 0;
        total     = '0;
        foreach (ring[i]) ring[i] = '0;
      end
    endcase
    if (found) begin
      rec = ring[(wr_ptr + DEPTH - held + age) % DEPTH];
      o.record_valid       = 1'b1;
      o.out_timestamp      = rec.timestamp;
      o.out_pit_temp       = rec.pit_temp;
      o.out_probe_one_temp = rec.probe_one_temp;
      o.out_probe_two_temp = rec.probe_two_temp;
      o.out_fan_percent    = rec.fan_percent;
      o.out_damper_percent = rec.damper_percent;
      o.out_flag_bits      = rec.flag_bits;
    end
    o.stored_count   = COUNT_W'(held);
    o.pending_count  = COUNT_W'(undrained);
    o.total_appended = total;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
             $time, result_no, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Request generation. The generator tracks only how many records the
  // ring holds, so that read ages can be aimed at held records and at the
  // first age past the end.
  // ---------------------------------------------------------------------
  int unsigned gen_held = 0;

  // All fields random; a request type only uses some of them, and the
  // rest are noise that the block must ignore.
  function automatic req_t noise_req(logic [1:0] kind);
    logic [127:0] raw;
    req_t         r;
    raw = {$urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.req_type = kind;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_temp();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t append_req();
    req_t r;
    r = noise_req(REQ_APPEND);
    r.in_pit_temp       = pick_temp();
    r.in_probe_one_temp = pick_temp();
    r.in_probe_two_temp = pick_temp();
    r.in_fan_percent    = 7'($urandom_range(0, 100));
    r.in_damper_percent = 7'($urandom_range(0, 100));
    return r;
  endfunction

  function automatic req_t rec_req(logic [31:0] ts, logic signed [15:0] pit,
                                   logic signed [15:0] p1, logic signed [15:0] p2,
                                   logic [6:0] fan, logic [6:0] damper, logic [7:0] flags);
    req_t r;
    r = noise_req(REQ_APPEND);
    r.in_timestamp      = ts;
    r.in_pit_temp       = pit;
    r.in_probe_one_temp = p1;
    r.in_probe_two_temp = p2;
    r.in_fan_percent    = fan;
    r.in_damper_percent = damper;
    r.in_flag_bits      = flags;
    return r;
  endfunction

  function automatic req_t read_req(logic [AGE_W-1:0] age);
    req_t r;
    r = noise_req(REQ_READ);
    r.age_index = age;
    return r;
  endfunction

  // Mostly held ages, some exactly one past the newest, some anything.
  function automatic logic [AGE_W-1:0] pick_age();
    int sel;
    sel = $urandom_range(0, 99);
    if (gen_held > 0 && sel < 70) return AGE_W'($urandom_range(0, gen_held - 1));
    if (sel < 85) return AGE_W'(gen_held);
    return AGE_W'($urandom);
  endfunction

  task automatic queue_req(req_t r);
    if (r.req_type == REQ_APPEND && gen_held < DEPTH) gen_held++;
    if (r.req_type == REQ_CLEAR) gen_held = 0;
    queued_reqs.push_back(r);
  endtask

  // Random mix by percent weights; whatever is left over goes to clears.
  task automatic queue_mix(int n, int w_append, int w_read, int w_drain);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < w_append) queue_req(append_req());
      else if (sel < w_append + w_read) queue_req(read_req(pick_age()));
      else if (sel < w_append + w_read + w_drain) queue_req(noise_req(REQ_DRAIN));
      else queue_req(noise_req(REQ_CLEAR));
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents the next queued request at a falling edge once the
  // previous one has been taken, with a random gap in between. Most gaps
  // are short, a few are long, and now and then a burst of requests goes
  // out back to back.
  // ---------------------------------------------------------------------
  int   burst_left = 0;
  int   gap_left = 0;
  logic took = 1'b0;

  function automatic int draw_gap();
    int sel;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      // Either nothing is offered or the offered request was just taken.
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (queued_reqs.size() > 0) begin
        start    <= 1'b1;
        req      <= queued_reqs.pop_front();
        gap_left <= draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: at each rising edge, a taken request steps the predictor and
  // a result marked by done is checked against the oldest prediction. The
  // prediction is made first so that a result in the same cycle as its
  // request would still find it.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    resp_t fresh;
    resp_t want;
    if (!rst && start && !busy) begin
      log_ring_step(req, fresh);
      predicted_log.push_back(fresh);
    end
    took <= !rst && start && !busy;
    if (!rst && done) begin
      result_no++;
      if (predicted_log.size() == 0) begin
        report_mismatch("result with none expected, stored_count",
                        resp.stored_count, '0);
      end else begin
        want = predicted_log.pop_front();
        if (resp.record_valid !== want.record_valid)
          report_mismatch("record_valid", resp.record_valid, want.record_valid);
        if (resp.out_timestamp !== want.out_timestamp)
          report_mismatch("out_timestamp", resp.out_timestamp, want.out_timestamp);
        if (resp.out_pit_temp !== want.out_pit_temp)
          report_mismatch("out_pit_temp", resp.out_pit_temp, want.out_pit_temp);
        if (resp.out_probe_one_temp !== want.out_probe_one_temp)
          report_mismatch("out_probe_one_temp", resp.out_probe_one_temp,
                          want.out_probe_one_temp);
        if (resp.out_probe_two_temp !== want.out_probe_two_temp)
          report_mismatch("out_probe_two_temp", resp.out_probe_two_temp,
                          want.out_probe_two_temp);
        if (resp.out_fan_percent !== want.out_fan_percent)
          report_mismatch("out_fan_percent", resp.out_fan_percent, want.out_fan_percent);
        if (resp.out_damper_percent !== want.out_damper_percent)
          report_mismatch("out_damper_percent", resp.out_damper_percent,
                          want.out_damper_percent);
        if (resp.out_flag_bits !== want.out_flag_bits)
          report_mismatch("out_flag_bits", resp.out_flag_bits, want.out_flag_bits);
        if (resp.stored_count !== want.stored_count)
          report_mismatch("stored_count", resp.stored_count, want.stored_count);
        if (resp.pending_count !== want.pending_count)
          report_mismatch("pending_count", resp.pending_count, want.pending_count);
        if (resp.total_appended !== want.total_appended)
          report_mismatch("total_appended", resp.total_appended, want.total_appended);
      end
    end
  end

  // The whole run is bounded; a hung handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------
  initial begin
    // Directed part. Reads and drains on an empty ring return nothing.
    queue_req(read_req('0));
    queue_req(noise_req(REQ_DRAIN));
    queue_req(read_req('1));
    // Records at the extremes of every field, then one in the middle.
    queue_req(rec_req(32'h0000_0000, 16'sh8000, 16'sh8000, 16'sh8000, 7'd0, 7'd0, 8'h00));
    queue_req(rec_req(32'hFFFF_FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 7'd100, 7'd100,
                      8'hFF));
    queue_req(rec_req(32'h5A5A_A5A5, -16'sd1, 16'sd1, 16'sd1234, 7'd63, 7'd37, 8'hA5));
    // Every held age, the first age past the newest record, and the top age.
    queue_req(read_req(10'd0));
    queue_req(read_req(10'd1));
    queue_req(read_req(10'd2));
    queue_req(read_req(10'd3));
    queue_req(read_req('1));
    // Drains come out oldest first, reads in between leave pending alone,
    // and a drain with nothing pending returns no record.
    queue_req(noise_req(REQ_DRAIN));
    queue_req(noise_req(REQ_DRAIN));
    queue_req(read_req(10'd0));
    queue_req(noise_req(REQ_DRAIN));
    queue_req(noise_req(REQ_DRAIN));
    queue_req(append_req());
    queue_req(noise_req(REQ_DRAIN));
    queue_req(read_req(10'd3));
    // Clear empties everything, and clearing an empty ring is harmless.
    queue_req(noise_req(REQ_CLEAR));
    queue_req(read_req(10'd0));
    queue_req(noise_req(REQ_DRAIN));
    queue_req(append_req());
    queue_req(read_req(10'd0));
    queue_req(noise_req(REQ_CLEAR));
    queue_req(noise_req(REQ_CLEAR));

    // Random part. First a busy mix with occasional clears, which keeps the
    // ring shallow. Then a long run that is mostly appends with no clear:
    // it fills the ring, overwrites the oldest records and drives the
    // pending count into saturation, with reads at all ages along the way.
    // Last, a drain-heavy stretch that walks the pending records out of a
    // full ring. The wrap of the 32-bit append total is out of reach in
    // any practical run length.
    queue_mix(350, 45, 25, 25);
    queue_mix(1150, 92, 6, 2);
    queue_mix(150, 20, 20, 60);

    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Requests and start only change at falling edges, so they are read at
    // rising edges; the prediction queue only changes at rising edges.
    @(posedge clk);
    while (queued_reqs.size() != 0 || start) @(posedge clk);
    @(negedge clk);
    while (predicted_log.size() != 0) @(negedge clk);
    // Run on for TAIL_CYCLES so that a stray extra result would still be seen.
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/orsl_pkg.sv
hw/rtl/orsl_ctrl.sv
hw/rtl/orsl_dp.sv
hw/rtl/overwrite_ring_sample_log.sv
hw/rtl/orsl_checker.sv
dv/overwrite_ring_sample_log_tb.sv
